/* hw/rtl/stcb_pkg.sv */
// ============================================================================
// stcb_pkg
// Shared types and constants of the scrolling text console buffer: request
// kinds, the queue entry and the response payload.
// ============================================================================
package stcb_pkg;

   // Character codes the front end looks for
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LAST  = 8'h7F;

   // Request kinds after classification
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_PRINT    = 3'd0;
   localparam kind_type KIND_NEWLINE  = 3'd1;
   localparam kind_type KIND_CR       = 3'd2;
   localparam kind_type KIND_DROP     = 3'd3;
   localparam kind_type KIND_READ     = 3'd4;
   localparam kind_type KIND_READ_OOR = 3'd5;

   // Decoupling queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

   // Classified request
   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      logic [4:0] row;
      logic [6:0] col;
   } entry_type;

   // Response payload
   typedef struct packed {
      logic        scrolled;
      logic [31:0] generation;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [7:0]  read_char;
   } rsp_type;

endpackage

/* hw/rtl/stcb_front.sv */
// ============================================================================
// stcb_front
// Accepts requests and classifies them: put bytes are mapped to print,
// newline, carriage return or drop; reads are checked against the grid.
// ============================================================================
module stcb_front #(
   parameter int ROWS = 32,
   parameter int COLS = 128
) (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_op,
   input  logic [7:0]           req_char_code,
   input  logic [4:0]           req_read_row,
   input  logic [6:0]           req_read_col,
   input  logic                 clearing,
   output logic                 push_valid,
   input  logic                 push_ready,
   output stcb_pkg::entry_type  push_entry
);
   import stcb_pkg::*;

   logic in_grid;

   // No request taken while the store is being cleared
   assign push_valid = req_tvalid & ~clearing;
   assign req_tready = push_ready & ~clearing;

   assign in_grid = ({27'd0, req_read_row} < 32'(ROWS)) &&
                    ({25'd0, req_read_col} < 32'(COLS));

   // Classification
   always_comb begin
      push_entry.chr = req_char_code;
      push_entry.row = req_read_row;
      push_entry.col = req_read_col;
      if (req_op) begin
         push_entry.kind = in_grid ? KIND_READ : KIND_READ_OOR;
      end else if (req_char_code == CHAR_TAB) begin
         push_entry.kind = KIND_PRINT;
         push_entry.chr  = CHAR_SPACE;
      end else if (req_char_code == CHAR_NL) begin
         push_entry.kind = KIND_NEWLINE;
      end else if (req_char_code == CHAR_CR) begin
         push_entry.kind = KIND_CR;
      end else if (req_char_code inside {[CHAR_SPACE:CHAR_LAST]}) begin
         push_entry.kind = KIND_PRINT;
      end else begin
         push_entry.kind = KIND_DROP;
      end
   end

endmodule

/* hw/rtl/stcb_queue.sv */
// ============================================================================
// stcb_queue
// Short request queue between front and back end so that each side can
// stall on its own.
// ============================================================================
module stcb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  stcb_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output stcb_pkg::entry_type  pop_entry
);
   import stcb_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/stcb_back.sv */
// ============================================================================
// stcb_back
// Executes classified requests: owns the character store, cursor, top-row
// pointer and generation count, runs the reset clear and row scroll sweeps,
// and holds the response register.
// ============================================================================
module stcb_back #(
   parameter int ROWS = 32,
   parameter int COLS = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  stcb_pkg::entry_type  pop_entry,
   output logic                 clearing,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stcb_pkg::rsp_type    rsp_data
);
   import stcb_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_SWEEP = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [31:0]   gen_ff, gen_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [RW-1:0] swp_row_ff, swp_row_in;
   logic [CW-1:0] swp_col_ff, swp_col_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    mem_ff [CELLS];

   logic          out_free;
   logic          load_rsp;
   logic          scroll;
   logic          is_read;
   logic [RW-1:0] vrow;
   logic [CW-1:0] vcol;
   logic [RW:0]   psum;
   logic [RW-1:0] prow;
   logic [RW-1:0] addr_row;
   logic [CW-1:0] addr_col;
   logic [AW-1:0] cell_addr;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   assign clearing  = (state_ff == ST_CLEAR);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Visible to physical row: one add and one conditional subtract
   assign is_read = (pop_entry.kind == KIND_READ);
   assign vrow    = is_read ? RW'(pop_entry.row) : row_ff;
   assign vcol    = is_read ? CW'(pop_entry.col) : col_ff;
   assign psum    = {1'b0, top_ff} + {1'b0, vrow};
   assign prow    = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : RW'(psum);

   // Cell address: scroll sweep or current request
   assign addr_row  = (state_ff == ST_SWEEP) ? swp_row_ff : prow;
   assign addr_col  = (state_ff == ST_SWEEP) ? swp_col_ff : vcol;
   assign cell_addr = AW'(addr_row) * AW'(COLS) + AW'(addr_col);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      gen_in       = gen_ff;
      clr_addr_in  = clr_addr_ff;
      swp_row_in   = swp_row_ff;
      swp_col_in   = swp_col_ff;
      rsp_in       = rsp_ff;
      load_rsp     = 1'b0;
      scroll       = 1'b0;
      pop_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cell_addr;
      mem_wdata    = pop_entry.chr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == AW'(CELLS-1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               load_rsp  = 1'b1;
               case (pop_entry.kind)
                  KIND_PRINT: begin
                     mem_we = 1'b1;
                     gen_in = gen_ff + 1'b1;
                     if (col_ff == CW'(COLS-1)) begin
                        scroll = (row_ff == RW'(ROWS-1));
                        col_in = '0;
                        if (!scroll) begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  KIND_NEWLINE: begin
                     gen_in = gen_ff + 1'b1;
                     scroll = (row_ff == RW'(ROWS-1));
                     col_in = '0;
                     if (!scroll) begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  KIND_CR: begin
                     gen_in = gen_ff + 1'b1;
                     col_in = '0;
                  end
                  KIND_DROP: begin
                     gen_in = gen_ff + 1'b1;
                  end
                  KIND_READ: begin
                     mem_re   = 1'b1;
                     load_rsp = 1'b0;
                     state_in = ST_READ;
                  end
                  default: begin
                     // read outside the grid: cell reads as zero
                  end
               endcase
               // Scroll: advance top row and blank the old one
               if (scroll) begin
                  top_in     = (top_ff == RW'(ROWS-1)) ? '0 : top_ff + 1'b1;
                  swp_row_in = top_ff;
                  swp_col_in = '0;
                  state_in   = ST_SWEEP;
               end
               rsp_in.read_char  = '0;
               rsp_in.cursor_row = 5'(row_in);
               rsp_in.cursor_col = 7'(col_in);
               rsp_in.generation = gen_in;
               rsp_in.scrolled   = scroll;
            end
         end
         ST_READ: begin
            load_rsp          = 1'b1;
            rsp_in.read_char  = rd_data_ff;
            rsp_in.cursor_row = 5'(row_ff);
            rsp_in.cursor_col = 7'(col_ff);
            rsp_in.generation = gen_ff;
            rsp_in.scrolled   = 1'b0;
            state_in          = ST_IDLE;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_wdata = CHAR_SPACE;
            if (swp_col_ff == CW'(COLS-1)) begin
               state_in = ST_IDLE;
            end else begin
               swp_col_in = swp_col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response slot
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         gen_ff       <= '0;
         clr_addr_ff  <= '0;
         swp_row_ff   <= '0;
         swp_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         gen_ff       <= gen_in;
         clr_addr_ff  <= clr_addr_in;
         swp_row_ff   <= swp_row_in;
         swp_col_ff   <= swp_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Character store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem_ff[cell_addr];
      end
   end

endmodule

/* hw/rtl/scrolling_text_console_buffer_top.sv */
// ============================================================================
// scrolling_text_console_buffer_top
// Character grid console with cursor, scrolling and cell read-back.
// ============================================================================
// Usage:
//   Requests enter on req_* (tuser 0 = put byte, 1 = read cell); every
//   request yields exactly one response on rsp_*, in request order.
//   A put returns the cursor after the byte, the generation count and a
//   scroll flag; a read returns the cell at a visible row and column, or
//   zero outside the grid.
//   A put answers in the cycle after it leaves the request queue; a read
//   passes the registered store read port, then the response register.
//   Sustained rate is one put per cycle while responses are taken and no
//   sweep runs; a read holds the back end in its read state, so no new
//   request is taken until the read has loaded its response. A put that
//   scrolls answers at once, then the back end blanks the new bottom row
//   with spaces, one cell per cycle, before the next request. After reset
//   the store is cleared to zeros one cell per cycle, with req_tready low.
//   A stalled response holds in the output register; the two-entry request
//   queue keeps accepting until it fills, then req_tready drops.
// ============================================================================
module scrolling_text_console_buffer_top #(
   parameter int ROWS = 32,
   parameter int COLS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zeros
   input  logic        req_tuser,   // op: 0 put, 1 read
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // read_char[7:0], cursor_row[12:8], cursor_col[19:13],
                                    // generation[51:20], scrolled[52], zeros
);
   import stcb_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;
   logic      clearing;
   rsp_type   rsp_data;

   // Front end: accept and classify
   stcb_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_op        (req_tuser),
      .req_char_code (req_tdata[7:0]),
      .req_read_row  (req_tdata[12:8]),
      .req_read_col  (req_tdata[19:13]),
      .clearing      (clearing),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   // Request queue
   stcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back end: store, cursor, responses
   stcb_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .clearing  (clearing),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {3'd0, rsp_data};

endmodule

/* tb/tb_scrolling_text_console_buffer_top.sv */
// ============================================================================
// tb_scrolling_text_console_buffer_top
// Self-checking bench for the scrolling text console buffer.
// A shadow copy of the character grid, cursor, top-row pointer and put count
// predicts the status of every request. Responses are checked field by field
// in order. Traffic is mostly text lines with random content, line wraps,
// scrolls and cell read-backs, mixed with control and out-of-range bytes.
// ============================================================================
module tb_scrolling_text_console_buffer_top;
   import stcb_pkg::*;

   localparam int GRID_ROWS      = 32;
   localparam int GRID_COLS      = 128;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int SETTLE_CYCLES  = 300;

   // Request kinds carried on req_tuser
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // char_code[7:0], read_row[12:8], read_col[19:13], zeros
   logic        req_tuser  = 1'b0; // op: 0 put, 1 read
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // read_char[7:0], cursor_row[12:8], cursor_col[19:13],
                                   // generation[51:20], scrolled[52], zeros

   // Shadow console state
   logic [7:0]  shadow_grid [GRID_ROWS*GRID_COLS];
   int          shadow_top;
   int          shadow_row;
   int          shadow_col;
   logic [31:0] shadow_puts;

   rsp_type     pending_status[$];
   int          mismatch_count = 0;
   int          sent_count     = 0;
   bit          idling_on      = 1'b1;

   scrolling_text_console_buffer_top #(
      .ROWS(GRID_ROWS),
      .COLS(GRID_COLS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= !idling_on || ($urandom_range(99) >= 33);
   end

   // ---------------------------------------------------------------------
   // Shadow model
   // ---------------------------------------------------------------------
   function automatic int cell_index(int vrow, int col);
      return ((shadow_top + vrow) % GRID_ROWS) * GRID_COLS + col;
   endfunction

   // Cursor to column 0 of the next row; returns 1 when the grid scrolls
   function automatic logic advance_line();
      shadow_col = 0;
      if (shadow_row + 1 >= GRID_ROWS) begin
         for (int c = 0; c < GRID_COLS; c++) shadow_grid[shadow_top*GRID_COLS + c] = CHAR_SPACE;
         shadow_top = (shadow_top + 1) % GRID_ROWS;
         shadow_row = GRID_ROWS - 1;
         return 1'b1;
      end
      shadow_row++;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_console_step(logic op, logic [7:0] code,
                                                    logic [4:0] rrow, logic [6:0] rcol);
      rsp_type    st;
      logic [7:0] c;
      st = '0;
      if (op == OP_PUT) begin
         c = (code == CHAR_TAB) ? CHAR_SPACE : code;
         if (c == CHAR_NL) begin
            st.scrolled = advance_line();
         end else if (c == CHAR_CR) begin
            shadow_col = 0;
         end else if (c >= CHAR_SPACE && c <= CHAR_LAST) begin
            shadow_grid[cell_index(shadow_row, shadow_col)] = c;
            shadow_col++;
            if (shadow_col >= GRID_COLS) st.scrolled = advance_line();
         end
         shadow_puts++;
      end else if (rrow < GRID_ROWS && rcol < GRID_COLS) begin
         st.read_char = shadow_grid[cell_index(int'(rrow), int'(rcol))];
      end
      st.cursor_row = shadow_row[4:0];
      st.cursor_col = shadow_col[6:0];
      st.generation = shadow_puts;
      return st;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   task automatic send_request(input logic op, input logic [7:0] code,
                               input logic [4:0] rrow, input logic [6:0] rcol);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, rcol, rrow, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_status.push_back(predict_console_step(op, code, rrow, rcol));
      sent_count++;
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Put with random content in the unused read fields
   task automatic put_byte(input logic [7:0] code);
      send_request(OP_PUT, code, 5'($urandom_range(31)), 7'($urandom_range(127)));
   endtask

   // Read with random content in the unused byte field
   task automatic read_cell(input int rrow, input int rcol);
      send_request(OP_READ, 8'($urandom_range(255)), rrow[4:0], rcol[6:0]);
   endtask

   task automatic put_printable_run(input int count);
      repeat (count) put_byte(8'($urandom_range(8'h20, 8'h7F)));
   endtask

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : response_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("response with none outstanding", 64'(rsp_tdata), 64'd0);
         end else begin
            got  = rsp_tdata[52:0];
            want = pending_status.pop_front();
            if (got.read_char != want.read_char)
               report_mismatch("read_char", 64'(got.read_char), 64'(want.read_char));
            if (got.cursor_row != want.cursor_row)
               report_mismatch("cursor_row", 64'(got.cursor_row), 64'(want.cursor_row));
            if (got.cursor_col != want.cursor_col)
               report_mismatch("cursor_col", 64'(got.cursor_col), 64'(want.cursor_col));
            if (got.generation != want.generation)
               report_mismatch("generation", 64'(got.generation), 64'(want.generation));
            if (got.scrolled != want.scrolled)
               report_mismatch("scrolled", 64'(got.scrolled), 64'(want.scrolled));
         end
      end
   end

   // Stall watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAIL scrolling_text_console_buffer_top");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Control bytes, tab, high bytes and printable extremes, then read-back
   task automatic test_control_bytes();
      put_byte(8'h00);
      put_byte(8'h1F);
      put_byte(CHAR_SPACE);
      put_byte(8'h41);
      put_byte(CHAR_LAST);
      put_byte(8'h7E);
      put_byte(CHAR_TAB);
      put_byte(8'h80);
      put_byte(8'hFF);
      put_byte(8'h08);
      put_byte(CHAR_CR);
      put_byte(8'h5A);
      put_byte(CHAR_NL);
      for (int c = 0; c < 6; c++) read_cell(0, c);
      read_cell(0, GRID_COLS - 1);
      read_cell(GRID_ROWS - 1, 0);
      read_cell(GRID_ROWS - 1, GRID_COLS - 1);
      read_cell(1, 0);
      stop_requests();
   endtask

   // A full line wraps the cursor; no idling on either side here
   task automatic test_line_wrap();
      idling_on = 1'b0;
      put_printable_run(GRID_COLS + 3);
      read_cell(shadow_row - 1, GRID_COLS - 1);
      read_cell(shadow_row - 1, 0);
      read_cell(shadow_row, 2);
      stop_requests();
      idling_on = 1'b1;
   endtask

   // Walk down to the bottom row, then scroll by newline and by wrap
   task automatic test_scroll();
      while (shadow_row < GRID_ROWS - 1) put_byte(CHAR_NL);
      repeat (3) put_byte(CHAR_NL);
      read_cell(GRID_ROWS - 1, 0);
      read_cell(GRID_ROWS - 1, GRID_COLS - 1);
      read_cell(0, 0);
      put_printable_run(GRID_COLS);
      read_cell(GRID_ROWS - 2, GRID_COLS - 1);
      read_cell(GRID_ROWS - 1, 5);
      stop_requests();
   endtask

   // The sender holds off until every outstanding response is back
   task automatic test_drain_pause();
      put_printable_run(10);
      put_byte(CHAR_NL);
      stop_requests();
      while (pending_status.size() > 0) @(posedge clock);
      put_printable_run(5);
      read_cell(shadow_row, 0);
      read_cell(shadow_row - 1, 3);
      stop_requests();
   endtask

   // Text lines of random length with noise and read-backs mixed in
   task automatic test_random_traffic();
      int line_len;
      int pick;
      int stop_at;
      stop_at = sent_count + RANDOM_ITEMS;
      while (sent_count < stop_at) begin
         line_len = ($urandom_range(99) < 85) ? $urandom_range(0, 30)
                                              : $urandom_range(100, 200);
         // one stretch with no idling at all
         idling_on = !(sent_count > stop_at - 400 && sent_count < stop_at - 250);
         for (int i = 0; i < line_len; i++) begin
            pick = $urandom_range(99);
            if (pick < 78) put_byte(8'($urandom_range(8'h20, 8'h7F)));
            else if (pick < 82) put_byte(CHAR_TAB);
            else if (pick < 85) put_byte(8'($urandom_range(255)));
            else if (pick < 87) put_byte(CHAR_CR);
            else if (pick < 93) read_cell(shadow_row, $urandom_range(GRID_COLS - 1));
            else read_cell($urandom_range(31), $urandom_range(127));
         end
         put_byte(($urandom_range(99) < 90) ? CHAR_NL : CHAR_CR);
      end
      idling_on = 1'b1;
      stop_requests();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) shadow_grid[i] = 8'h00;
      shadow_top  = 0;
      shadow_row  = 0;
      shadow_col  = 0;
      shadow_puts = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_control_bytes();
      test_line_wrap();
      test_scroll();
      test_drain_pause();
      test_random_traffic();

      while (pending_status.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("PASS scrolling_text_console_buffer_top");
      end else begin
         $display("FAIL scrolling_text_console_buffer_top");
      end
      $finish;
   end

endmodule
